// File: src/mfbp_pkg.sv
`default_nettype none

package mfbp_pkg;

  // Panel geometry
  localparam int PANEL_WIDTH      = 400;
  localparam int PANEL_HEIGHT     = 300;
  localparam int PAGE_HEIGHT      = 300;
  localparam int BUFFER_BYTES_DEF = 15000;

  // Widths fixed by the coordinate and index ranges
  localparam int COORD_W      = 11;  // panel coordinate, below 2048
  localparam int PROD_W       = 22;  // row times panel width
  localparam int IDX_W        = 20;  // full byte index before the range check
  localparam int ADDR_MAX_W   = 16;  // widest store address
  localparam int READ_INDEX_W = 14;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

  // Configuration register indexes
  localparam logic REG_ROTATION = 1'b0;
  localparam logic REG_PAGE     = 1'b1;

  typedef enum logic {
    OP_PLOT = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MODIFY
  } back_state_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [15:0]       pixel_x;
    logic signed [15:0]       pixel_y;
    logic                     pixel_white;
    logic [READ_INDEX_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       pixel_written;
  } result_t;

  // Classified operation handed from front to back
  typedef struct packed {
    op_t                    operation;
    logic                   hit;
    logic                   white;
    logic [7:0]             mask;
    logic [ADDR_MAX_W-1:0]  addr;
  } entry_t;

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// File: src/mfbp_ram.sv
`default_nettype none

module mfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/mfbp_front.sv
`default_nettype none

module mfbp_front
  import mfbp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire item_t      item,
  input  wire logic [1:0] rotation,
  input  wire logic [3:0] page_number,
  input  wire logic       clearing,
  input  wire logic       q_full,
  output logic            push,
  output entry_t          entry
);

  localparam int AW = addr_width(BUFFER_BYTES);

  logic                    s1_valid;
  op_t                     s1_op;
  logic                    s1_white;
  logic                    s1_drop;
  logic [COORD_W-1:0]      s1_px;
  logic [COORD_W-1:0]      s1_row;
  logic [READ_INDEX_W-1:0] s1_read_index;

  logic                    accept;
  logic [15:0]             lw, lh, xu, yu;
  logic                    clip;
  logic [COORD_W-1:0]      xc, yc, px, py, row;
  logic [15:0]             page_off;
  logic signed [16:0]      rel;
  logic                    page_drop;
  logic [PROD_W-1:0]       prod;
  logic [IDX_W-1:0]        idx;
  logic                    hit;

  assign push       = s1_valid && !q_full;
  assign item_ready = !clearing && (!s1_valid || !q_full);
  assign accept     = item_valid && item_ready;

  // Clip against the logical size for this rotation
  always_comb begin
    lw   = rotation[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
    lh   = rotation[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
    xu   = item.pixel_x;
    yu   = item.pixel_y;
    clip = xu[15] || yu[15] || (xu >= lw) || (yu >= lh);
    xc   = xu[COORD_W-1:0];
    yc   = yu[COORD_W-1:0];
  end

  // Map logical point to panel coordinates
  always_comb begin
    case (rotation)
      2'd1: begin
        px = COORD_W'(PANEL_WIDTH - 1) - yc;
        py = xc;
      end
      2'd2: begin
        px = COORD_W'(PANEL_WIDTH - 1) - xc;
        py = COORD_W'(PANEL_HEIGHT - 1) - yc;
      end
      2'd3: begin
        px = yc;
        py = COORD_W'(PANEL_HEIGHT - 1) - xc;
      end
      default: begin
        px = xc;
        py = yc;
      end
    endcase
  end

  // Apply the page offset and clip to the page
  always_comb begin
    page_off  = 16'(page_number) * 16'(PAGE_HEIGHT);
    rel       = $signed({6'b0, py}) - $signed({1'b0, page_off});
    page_drop = 1'b0;
    row       = py;
    if (page_number != 4'd0) begin
      page_drop = (rel < 0) || (rel >= 17'sd0 + 17'(PAGE_HEIGHT));
      row       = rel[COORD_W-1:0];
    end
  end

  // Stage 1: hold the mapped point until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op         <= item.operation;
      s1_white      <= item.pixel_white;
      s1_drop       <= clip || page_drop;
      s1_px         <= px;
      s1_row        <= row;
      s1_read_index <= item.read_index;
    end
  end

  // Stage 2: byte index, range check and bit mask
  always_comb begin
    prod = PROD_W'(s1_row) * PROD_W'(PANEL_WIDTH);
    if (s1_op == OP_READ) begin
      idx = IDX_W'(s1_read_index);
      hit = idx < IDX_W'(BUFFER_BYTES);
    end else begin
      idx = IDX_W'(s1_px >> 3) + IDX_W'(prod >> 3);
      hit = !s1_drop && (idx < IDX_W'(BUFFER_BYTES));
    end
    entry.operation = s1_op;
    entry.hit       = hit;
    entry.white     = s1_white;
    entry.mask      = 8'h80 >> s1_px[2:0];
    entry.addr      = ADDR_MAX_W'(idx[AW-1:0]);
  end

endmodule

`default_nettype wire

// File: src/mfbp_queue.sv
`default_nettype none

module mfbp_queue
  import mfbp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign full       = count == (PW + 1)'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: src/mfbp_back.sv
`default_nettype none

module mfbp_back
  import mfbp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        clearing,
  output logic        result_valid,
  input  wire logic   result_ready,
  output result_t     result
);

  localparam int AW = addr_width(BUFFER_BYTES);

  back_state_t     state, state_next;
  logic [AW-1:0]   clear_addr;
  entry_t          cur;
  result_t         result_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;
  logic            clear_done;
  logic            slot_free;

  assign clear_done = clear_addr == AW'(BUFFER_BYTES - 1);
  assign slot_free  = !result_valid || result_ready;

  mfbp_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR:  if (clear_done) state_next = BK_IDLE;
      BK_IDLE:   if (head_valid && slot_free) state_next = BK_MODIFY;
      BK_MODIFY: state_next = BK_IDLE;
      default:   state_next = BK_CLEAR;
    endcase
  end

  // Outputs: store writes, queue pop, result value
  always_comb begin
    pop         = 1'b0;
    clearing    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur.addr[AW-1:0];
    ram_wdata   = cur.white ? (ram_rdata & ~cur.mask) : (ram_rdata | cur.mask);
    result_next = '0;
    if (cur.operation == OP_READ) begin
      result_next.read_byte = cur.hit ? ~ram_rdata : BYTE_ALL_ONES;
    end else begin
      result_next.pixel_written = cur.hit;
    end
    unique case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        pop = head_valid && slot_free;
      end
      BK_MODIFY: begin
        ram_we = (cur.operation == OP_PLOT) && cur.hit;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Hold the operation in flight while the store read returns
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == BK_MODIFY) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_MODIFY) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: src/mono_frame_buffer_pixel_plotter.sv
// Channel  Handshake                      Payload
// item     item_valid / item_ready        item_t: plot point or read index
// result   result_valid / result_ready    result_t: read byte, plot landed
// cfg      cfg_we (no wait)               cfg_index, cfg_data
//
// In the back part each item has a frame store read, then the modify-write
// with the result load; a new item is taken only once the last has finished.
// An item passes the stage-1 register, the queue, the store read and
// the modify-write before its result is registered. After reset the store
// is cleared one byte a cycle with item_ready low. A stalled result stops
// only the back part; the front keeps taking items until its queue fills.
`default_nettype none

module mono_frame_buffer_pixel_plotter
  import mfbp_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire item_t      item,
  output logic            result_valid,
  input  wire logic       result_ready,
  output result_t         result,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic [1:0] rotation;
  logic [3:0] page_number;
  logic       clearing;
  logic       push, q_full, pop, head_valid;
  entry_t     entry, head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation    <= '0;
      page_number <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROTATION: rotation    <= cfg_data[1:0];
        REG_PAGE:     page_number <= cfg_data;
        default:      ;
      endcase
    end
  end

  mfbp_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .rotation    (rotation),
    .page_number (page_number),
    .clearing    (clearing),
    .q_full      (q_full),
    .push        (push),
    .entry       (entry)
  );

  mfbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mfbp_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: src/mfbp_checker.sv
`default_nettype none

module mfbp_checker
  import mfbp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire result_t    result
);

  logic [2:0] outstanding;
  logic       item_fire, result_fire;

  assign item_fire   = item_valid && item_ready;
  assign result_fire = result_valid && result_ready;

  // Track transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (item_fire && !result_fire) begin
      outstanding <= outstanding + 1'b1;
    end else if (result_fire && !item_fire) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // The clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("item_ready high in the cycle after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 3'd0)
    else $error("result shown with no transaction outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd5)
    else $error("more transactions in flight than the pipeline holds");

  a_plot_zero_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pixel_written |-> result.read_byte == 8'h00)
    else $error("plot result carries a nonzero byte");

endmodule

bind mono_frame_buffer_pixel_plotter mfbp_checker u_mfbp_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfbp_pkg::*;

  localparam int   HOLD_CYCLES  = 200;
  localparam int   DRAIN_CYCLES = 10;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   REPORT_MAX   = 10;

  // Shadow copy of the frame store plus the expected results in flight
  class frame_scoreboard;
    logic [7:0] shadow [BUFFER_BYTES_DEF];
    logic [1:0] rot;
    logic [3:0] page;
    result_t    pending [$];
    int         mismatches;
    int         last_byte;
    int         result_count;

    function new();
      foreach (shadow[i]) shadow[i] = 8'h00;
      rot          = 2'd0;
      page         = 4'd0;
      mismatches   = 0;
      last_byte    = 0;
      result_count = 0;
    endfunction

    function void write_reg(input logic idx, input logic [3:0] data);
      if (idx == REG_ROTATION) rot = data[1:0];
      else page = data;
    endfunction

    // Predict the result of one accepted transaction and update the shadow
    function void note_item(input item_t it);
      result_t    exp;
      int         x, y, lw, lh, px, py, pg, idx;
      logic [7:0] mask;
      exp = '0;
      if (it.operation == OP_READ) begin
        if (it.read_index < BUFFER_BYTES_DEF) exp.read_byte = ~shadow[it.read_index];
        else exp.read_byte = BYTE_ALL_ONES;
      end else begin
        x  = int'(it.pixel_x);
        y  = int'(it.pixel_y);
        lw = rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        lh = rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        if (x >= 0 && x < lw && y >= 0 && y < lh) begin
          case (rot)
            2'd1: begin
              px = PANEL_WIDTH - 1 - y;
              py = x;
            end
            2'd2: begin
              px = PANEL_WIDTH - 1 - x;
              py = PANEL_HEIGHT - 1 - y;
            end
            2'd3: begin
              px = y;
              py = PANEL_HEIGHT - 1 - x;
            end
            default: begin
              px = x;
              py = y;
            end
          endcase
          pg = int'(page);
          if (pg != 0) py = py - pg * PAGE_HEIGHT;
          if (pg == 0 || (py >= 0 && py < PAGE_HEIGHT)) begin
            idx = px / 8 + (py * PANEL_WIDTH) / 8;
            if (idx >= 0 && idx < BUFFER_BYTES_DEF) begin
              mask = 8'h80 >> (px & 7);
              if (it.pixel_white) shadow[idx] = shadow[idx] & ~mask;
              else shadow[idx] = shadow[idx] | mask;
              exp.pixel_written = 1'b1;
              last_byte = idx;
            end
          end
        end
      end
      pending.push_back(exp);
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(input result_t got);
      result_t exp;
      result_count++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result %0d unexpected: byte %02h written %0b", $realtime,
                   result_count, got.read_byte, got.pixel_written);
        return;
      end
      exp = pending.pop_front();
      if (got.read_byte !== exp.read_byte || got.pixel_written !== exp.pixel_written) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result %0d: expected byte %02h written %0b, got byte %02h written %0b",
                   $realtime, result_count, exp.read_byte, exp.pixel_written,
                   got.read_byte, got.pixel_written);
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_ready;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_we       = 1'b0;
  logic       cfg_index    = REG_ROTATION;
  logic [3:0] cfg_data     = 4'd0;

  frame_scoreboard scb = new();
  bit sender_idles    = 1'b0;
  bit receiver_stalls = 1'b0;
  bit hold_req        = 1'b0;
  int cycles          = 0;

  mono_frame_buffer_pixel_plotter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL mono_frame_buffer_pixel_plotter");
      $finish;
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) scb.check_result(result);
  end

  // Drive result_ready: random stall bursts and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        result_ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic item_t mk_plot(input int x, input int y, input bit white);
    item_t it;
    it.operation   = OP_PLOT;
    it.pixel_x     = x[15:0];
    it.pixel_y     = y[15:0];
    it.pixel_white = white;
    it.read_index  = READ_INDEX_W'($urandom);
    return it;
  endfunction

  function automatic item_t mk_read(input int idx);
    item_t it;
    it.operation   = OP_READ;
    it.pixel_x     = 16'($urandom);
    it.pixel_y     = 16'($urandom);
    it.pixel_white = 1'($urandom);
    it.read_index  = idx[READ_INDEX_W-1:0];
    return it;
  endfunction

  // Mostly in-range plots and reads around the last touched byte
  function automatic item_t gen_item();
    int r, lw, lh, b;
    r  = $urandom_range(0, 99);
    lw = scb.rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    lh = scb.rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    if (r < 45)
      return mk_plot($urandom_range(0, lw - 1), $urandom_range(0, lh - 1),
                     1'($urandom_range(0, 1)));
    if (r < 55)
      return mk_plot(int'($urandom_range(0, lw + 1)) - 1, int'($urandom_range(0, lh + 1)) - 1,
                     1'($urandom_range(0, 1)));
    if (r < 62)
      return mk_plot(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                     1'($urandom_range(0, 1)));
    if (r < 85) begin
      b = scb.last_byte + int'($urandom_range(0, 2)) - 1;
      if (b < 0) b = 0;
      return mk_read(b);
    end
    if (r < 95) return mk_read($urandom_range(0, BUFFER_BYTES_DEF - 1));
    return mk_read($urandom_range(0, (1 << READ_INDEX_W) - 1));
  endfunction

  // Offer one transaction, with an optional idle burst ahead of it
  task automatic send_item(input item_t it);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    scb.note_item(it);
  endtask

  task automatic apply_config(input logic [1:0] rot, input logic [3:0] page);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROTATION;
    cfg_data  <= {2'b00, rot};
    @(posedge clk);
    cfg_index <= REG_PAGE;
    cfg_data  <= page;
    @(posedge clk);
    cfg_we <= 1'b0;
    scb.write_reg(REG_ROTATION, {2'b00, rot});
    scb.write_reg(REG_PAGE, page);
  endtask

  // Stop offering and wait until every expected result is back
  task automatic drain();
    item_valid <= 1'b0;
    while (scb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] rot, input logic [3:0] page, input int count,
                           input bit idle, input bit hold);
    apply_config(rot, page);
    sender_idles    = idle;
    receiver_stalls = idle;
    if (hold) hold_req = 1'b1;
    repeat (count) send_item(gen_item());
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Wait out the clearing pass
    @(posedge clk);
    while (!item_ready) @(posedge clk);

    // Directed: corners, colors, clipping and reads past the buffer
    apply_config(2'd0, 4'd0);
    send_item(mk_plot(0, 0, 1'b0));
    send_item(mk_plot(PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1'b0));
    send_item(mk_plot(7, 0, 1'b0));
    send_item(mk_read(0));
    send_item(mk_read(BUFFER_BYTES_DEF - 1));
    send_item(mk_plot(0, 0, 1'b1));
    send_item(mk_read(0));
    send_item(mk_plot(-1, 0, 1'b0));
    send_item(mk_plot(0, -1, 1'b0));
    send_item(mk_plot(PANEL_WIDTH, 0, 1'b0));
    send_item(mk_plot(0, PANEL_HEIGHT, 1'b0));
    send_item(mk_plot(-32768, -32768, 1'b0));
    send_item(mk_plot(32767, 32767, 1'b1));
    send_item(mk_plot(-32768, 32767, 1'b0));
    send_item(mk_read(BUFFER_BYTES_DEF));
    send_item(mk_read((1 << READ_INDEX_W) - 1));
    send_item(mk_read(BUFFER_BYTES_DEF - 1));
    drain();
    // Page mode pushes every row off the page
    apply_config(2'd0, 4'd1);
    send_item(mk_plot(0, 0, 1'b0));
    send_item(mk_plot(PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1'b0));
    send_item(mk_read(0));
    drain();
    apply_config(2'd3, 4'd15);
    send_item(mk_plot(0, 0, 1'b0));
    send_item(mk_read(BUFFER_BYTES_DEF - 1));
    drain();

    // Random phases over rotations and pages, extremes first
    run_phase(2'd0, 4'd0, 130, 1'b1, 1'b0);
    run_phase(2'd1, 4'd0, 130, 1'b1, 1'b1);
    run_phase(2'd2, 4'd0, 130, 1'b1, 1'b0);
    run_phase(2'd3, 4'd0, 130, 1'b1, 1'b0);
    run_phase(2'd3, 4'd15, 80, 1'b1, 1'b0);
    run_phase(2'd1, 4'd1, 80, 1'b1, 1'b0);
    for (int p = 0; p < 7; p++)
      run_phase(2'($urandom_range(0, 3)),
                ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'd0,
                115, 1'b1, 1'b0);
    // Last part runs back to back
    run_phase(2'd2, 4'd0, 130, 1'b0, 1'b0);
    run_phase(2'd0, 4'd0, 130, 1'b0, 1'b0);

    if (scb.mismatches == 0 && scb.pending.size() == 0)
      $display("PASS mono_frame_buffer_pixel_plotter");
    else
      $display("FAIL mono_frame_buffer_pixel_plotter");
    $finish;
  end

endmodule

`default_nettype wire
